>>> design/usg_pkg.sv
package usg_pkg;

   localparam int CNT_W        = 9;
   localparam int IDX_W        = 8;
   localparam int RAD_W        = 16;
   localparam int POS_W        = 17;
   localparam int TRIG_W       = 18;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 34;

   // gain-compensated unit vector in Q30
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [POS_W-1:0]    POS_LIMIT    = 17'sd65535;

   typedef enum logic [1:0] {
      CSR_SECTOR_COUNT  = 2'd0,
      CSR_STACK_COUNT   = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CORNER_FIRST  = 2'd0,
      CORNER_SECOND = 2'd1,
      CORNER_THIRD  = 2'd2
   } corner_type;

   // upper triangle (k1, k2, k1+1) then lower triangle (k1+1, k2, k2+1)
   typedef enum logic [2:0] {
      STEP_UP_FIRST  = 3'd0,
      STEP_UP_SECOND = 3'd1,
      STEP_UP_THIRD  = 3'd2,
      STEP_DN_FIRST  = 3'd3,
      STEP_DN_SECOND = 3'd4,
      STEP_DN_THIRD  = 3'd5
   } step_type;

   typedef struct packed {
      logic [CNT_W-1:0] row;
      logic [CNT_W-1:0] col;
      corner_type       corner;
      logic             last;
   } vert_req_type;

   typedef struct packed {
      logic       valid;
      corner_type corner;
      logic       last;
   } vert_tag_type;

   // atan(2^-k) as a fraction of a 32-bit turn
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int k);
      logic signed [CORDIC_W-1:0] a;
      case (k)
         0:       a = 34'sd536870912;
         1:       a = 34'sd316933406;
         2:       a = 34'sd167458907;
         3:       a = 34'sd85004756;
         4:       a = 34'sd42667331;
         5:       a = 34'sd21354465;
         6:       a = 34'sd10679838;
         7:       a = 34'sd5340245;
         8:       a = 34'sd2670163;
         9:       a = 34'sd1335087;
         10:      a = 34'sd667544;
         11:      a = 34'sd333772;
         12:      a = 34'sd166886;
         13:      a = 34'sd83443;
         14:      a = 34'sd41722;
         15:      a = 34'sd20861;
         16:      a = 34'sd10430;
         17:      a = 34'sd5215;
         18:      a = 34'sd2608;
         19:      a = 34'sd1304;
         20:      a = 34'sd652;
         21:      a = 34'sd326;
         22:      a = 34'sd163;
         23:      a = 34'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

   // saturate to the coordinate range
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [23:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 24'sd65535) begin
         r = POS_LIMIT;
      end else if (v < -24'sd65535) begin
         r = -POS_LIMIT;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> design/usg_divider.sv
module usg_divider #(
   parameter int QB = 17
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [usg_pkg::CNT_W-1:0]   num,
   input  logic [usg_pkg::CNT_W-1:0]   den,
   output logic [QB-1:0]               quot
);

   // floor(num * 2^(QB-1) / den), one quotient bit per stage; num <= den
   logic [usg_pkg::CNT_W-1:0] rem_ff [QB];
   logic [usg_pkg::CNT_W-1:0] rem_in [QB];
   logic [QB-1:0]             q_ff   [QB];
   logic [QB-1:0]             q_in   [QB];

   always_comb begin
      logic [usg_pkg::CNT_W:0] part;
      logic [QB-1:0]           qp;
      logic                    hit;
      for (int k = 0; k < QB; k++) begin
         if (k == 0) begin
            part = {1'b0, num};
            qp   = '0;
         end else begin
            part = {rem_ff[k-1], 1'b0};
            qp   = q_ff[k-1];
         end
         hit = (part >= {1'b0, den});
         if (hit) begin
            part = part - {1'b0, den};
         end
         rem_in[k]     = part[usg_pkg::CNT_W-1:0];
         qp[QB-1-k]    = hit;
         q_in[k]       = qp;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QB; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign quot = q_ff[QB-1];

endmodule

>>> design/usg_cordic.sv
module usg_cordic (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [31:0]                         phase,
   output logic signed [usg_pkg::TRIG_W-1:0]   cos_q,
   output logic signed [usg_pkg::TRIG_W-1:0]   sin_q
);

   localparam int STEPS = usg_pkg::CORDIC_STEPS;
   localparam int W     = usg_pkg::CORDIC_W;

   logic                 flip_in;
   logic [31:0]          red;
   logic signed [W-1:0]  z0_ff;
   logic                 flip_ff [STEPS+1];
   logic signed [W-1:0]  x_ff [STEPS];
   logic signed [W-1:0]  y_ff [STEPS];
   logic signed [W-1:0]  z_ff [STEPS];
   logic signed [W-1:0]  x_in [STEPS];
   logic signed [W-1:0]  y_in [STEPS];
   logic signed [W-1:0]  z_in [STEPS];
   logic signed [W-1:0]  xr, yr;
   logic signed [usg_pkg::TRIG_W-1:0] cos_ff, sin_ff;

   // fold the second and third quadrant by a half turn, negate at the end
   always_comb begin
      flip_in = phase[31] ^ phase[30];
      red     = flip_in ? (phase ^ 32'h8000_0000) : phase;
   end

   always_comb begin
      logic signed [W-1:0] xp, yp, zp;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            xp = usg_pkg::CORDIC_START;
            yp = '0;
            zp = z0_ff;
         end else begin
            xp = x_ff[k-1];
            yp = y_ff[k-1];
            zp = z_ff[k-1];
         end
         if (!zp[W-1]) begin
            x_in[k] = xp - (yp >>> k);
            y_in[k] = yp + (xp >>> k);
            z_in[k] = zp - usg_pkg::atan_turn(k);
         end else begin
            x_in[k] = xp + (yp >>> k);
            y_in[k] = yp - (xp >>> k);
            z_in[k] = zp + usg_pkg::atan_turn(k);
         end
      end
   end

   // round half up to Q16 and clamp to one
   always_comb begin
      logic signed [W-1:0] xf, yf;
      xf = flip_ff[STEPS] ? -x_ff[STEPS-1] : x_ff[STEPS-1];
      yf = flip_ff[STEPS] ? -y_ff[STEPS-1] : y_ff[STEPS-1];
      xr = (xf + 34'sd8192) >>> 14;
      yr = (yf + 34'sd8192) >>> 14;
      if (xr > 34'sd65536) begin
         xr = 34'sd65536;
      end else if (xr < -34'sd65536) begin
         xr = -34'sd65536;
      end
      if (yr > 34'sd65536) begin
         yr = 34'sd65536;
      end else if (yr < -34'sd65536) begin
         yr = -34'sd65536;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z0_ff      <= {{(W-32){red[31]}}, red};
         flip_ff[0] <= flip_in;
         for (int k = 0; k < STEPS; k++) begin
            x_ff[k]      <= x_in[k];
            y_ff[k]      <= y_in[k];
            z_ff[k]      <= z_in[k];
            flip_ff[k+1] <= flip_ff[k];
         end
         cos_ff <= xr[usg_pkg::TRIG_W-1:0];
         sin_ff <= yr[usg_pkg::TRIG_W-1:0];
      end
   end

   assign cos_q = cos_ff;
   assign sin_q = sin_ff;

endmodule

>>> design/usg_vertex_seq.sv
module usg_vertex_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [usg_pkg::IDX_W-1:0]     stack_index,
   input  logic [usg_pkg::IDX_W-1:0]     sector_index,
   input  logic [usg_pkg::CNT_W-1:0]     sectors,
   input  logic [usg_pkg::CNT_W-1:0]     stacks,
   input  logic                          adv,
   output logic                          vr_valid,
   output usg_pkg::vert_req_type         vr
);

   logic                          act_ff, act_in;
   usg_pkg::step_type             step_ff, step_in, step_next;
   usg_pkg::step_type             end_ff, end_in;
   logic [usg_pkg::IDX_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic [usg_pkg::CNT_W-1:0]     row_w, col_w;
   logic                          top, bottom, cell_ok, acc, done, is_last;

   always_comb begin
      row_w   = {1'b0, stack_index};
      col_w   = {1'b0, sector_index};
      top     = (stack_index == '0);
      bottom  = (row_w == stacks - 1'b1);
      cell_ok = (stacks != '0) && (sectors != '0) && (row_w < stacks) &&
                (col_w < sectors) && !(top && bottom);
      is_last   = (step_ff == end_ff);
      done      = act_ff && adv && is_last;
      req_ready = !act_ff || done;
      acc       = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         step_ff <= usg_pkg::STEP_UP_FIRST;
         end_ff  <= usg_pkg::STEP_DN_THIRD;
      end else begin
         act_ff  <= act_in;
         step_ff <= step_in;
         end_ff  <= end_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
   end

   always_comb begin
      logic [usg_pkg::CNT_W-1:0] r0, r1, c0, c1;
      r0 = {1'b0, row_ff};
      r1 = r0 + 1'b1;
      c0 = {1'b0, col_ff};
      c1 = c0 + 1'b1;

      act_in  = act_ff;
      step_in = step_ff;
      end_in  = end_ff;
      row_in  = row_ff;
      col_in  = col_ff;

      unique case (step_ff)
         usg_pkg::STEP_UP_FIRST: begin
            step_next = usg_pkg::STEP_UP_SECOND;
            vr.row = r0; vr.col = c0; vr.corner = usg_pkg::CORNER_FIRST;
         end
         usg_pkg::STEP_UP_SECOND: begin
            step_next = usg_pkg::STEP_UP_THIRD;
            vr.row = r1; vr.col = c0; vr.corner = usg_pkg::CORNER_SECOND;
         end
         usg_pkg::STEP_UP_THIRD: begin
            step_next = usg_pkg::STEP_DN_FIRST;
            vr.row = r0; vr.col = c1; vr.corner = usg_pkg::CORNER_THIRD;
         end
         usg_pkg::STEP_DN_FIRST: begin
            step_next = usg_pkg::STEP_DN_SECOND;
            vr.row = r0; vr.col = c1; vr.corner = usg_pkg::CORNER_FIRST;
         end
         usg_pkg::STEP_DN_SECOND: begin
            step_next = usg_pkg::STEP_DN_THIRD;
            vr.row = r1; vr.col = c0; vr.corner = usg_pkg::CORNER_SECOND;
         end
         usg_pkg::STEP_DN_THIRD: begin
            step_next = usg_pkg::STEP_DN_THIRD;
            vr.row = r1; vr.col = c1; vr.corner = usg_pkg::CORNER_THIRD;
         end
         default: begin
            step_next = usg_pkg::STEP_UP_FIRST;
            vr.row = r0; vr.col = c0; vr.corner = usg_pkg::CORNER_FIRST;
         end
      endcase
      vr.last  = is_last;
      vr_valid = act_ff;

      if (acc) begin
         act_in  = cell_ok;
         step_in = top ? usg_pkg::STEP_DN_FIRST : usg_pkg::STEP_UP_FIRST;
         end_in  = bottom ? usg_pkg::STEP_UP_THIRD : usg_pkg::STEP_DN_THIRD;
         row_in  = stack_index;
         col_in  = sector_index;
      end else if (done) begin
         act_in = 1'b0;
      end else if (act_ff && adv) begin
         step_in = step_next;
      end
   end

   a_drop_outside: assert property (@(posedge clock) disable iff (reset)
      acc && !cell_ok |=> !act_ff)
      else $error("cell outside the grid started a vertex sequence");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      act_ff && is_last |-> vr.corner == usg_pkg::CORNER_THIRD)
      else $error("cell ended on a corner other than the third");

   a_ready_busy: assert property (@(posedge clock) disable iff (reset)
      act_ff && req_ready |-> adv && is_last)
      else $error("new cell taken before the current one finished");

endmodule

>>> design/uv_sphere_triangle_generator.sv
// UV-sphere triangle generator. Each transfer on req_ names one grid cell (stack i,
// sector j); the block answers with the vertices of up to two triangles on rsp_, three
// per triangle with rsp_corner 0..2, and rsp_last_of_cell marks the final vertex of the
// cell. The top stack gives only the lower triangle, the bottom stack only the upper
// one, and cells outside the configured grid (or any cell of a one-stack grid) are
// taken and give nothing. Every vertex runs through one pipeline: two restoring
// dividers produce the stack and sector phases one bit per stage, two 24-stage CORDICs
// give cos and sin, and two multiply stages scale by the radius. One vertex enters
// per cycle while the result channel accepts, so a full cell gives six vertices and a top
// or bottom cell three. Counts above MAX_SECTORS / MAX_STACKS act as the maximum.
// Write csr_ registers only while the block is idle; there is no read-back.
module uv_sphere_triangle_generator #(
   parameter int MAX_SECTORS = 256,
   parameter int MAX_STACKS  = 256,
   parameter int PHASE_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [usg_pkg::IDX_W-1:0]         req_stack_index,
   input  logic [usg_pkg::IDX_W-1:0]         req_sector_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [usg_pkg::POS_W-1:0]  rsp_pos_x,
   output logic signed [usg_pkg::POS_W-1:0]  rsp_pos_y,
   output logic signed [usg_pkg::POS_W-1:0]  rsp_pos_z,
   output logic [1:0]                        rsp_corner,
   output logic                              rsp_last_of_cell,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [usg_pkg::RAD_W-1:0]         csr_write_data
);

   localparam int CNT_MAX = (1 << usg_pkg::CNT_W) - 1;
   localparam int SEC_LIM = (MAX_SECTORS > CNT_MAX) ? CNT_MAX : MAX_SECTORS;
   localparam int STK_LIM = (MAX_STACKS > CNT_MAX) ? CNT_MAX : MAX_STACKS;
   localparam int QB      = PHASE_BITS + 1;
   // divider, phase register, CORDIC (fold + steps + round), two multiply stages
   localparam int TAG_LAT = QB + 1 + (usg_pkg::CORDIC_STEPS + 2) + 2;
   localparam int TRIG_W  = usg_pkg::TRIG_W;

   // configuration registers
   logic [usg_pkg::CNT_W-1:0] sector_count_ff, stack_count_ff;
   logic [usg_pkg::RAD_W-1:0] radius_ff;
   logic [usg_pkg::CNT_W-1:0] sectors, stacks;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_count_ff <= 9'd16;
         stack_count_ff  <= 9'd8;
         radius_ff       <= 16'd256;
      end else if (csr_write_enable) begin
         unique case (usg_pkg::csr_index_type'(csr_index))
            usg_pkg::CSR_SECTOR_COUNT:
               sector_count_ff <= csr_write_data[usg_pkg::CNT_W-1:0];
            usg_pkg::CSR_STACK_COUNT:
               stack_count_ff  <= csr_write_data[usg_pkg::CNT_W-1:0];
            usg_pkg::CSR_SPHERE_RADIUS:
               radius_ff       <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      sectors = (sector_count_ff > usg_pkg::CNT_W'(SEC_LIM)) ?
                usg_pkg::CNT_W'(SEC_LIM) : sector_count_ff;
      stacks  = (stack_count_ff > usg_pkg::CNT_W'(STK_LIM)) ?
                usg_pkg::CNT_W'(STK_LIM) : stack_count_ff;
   end

   // whole pipeline moves together; hold everything while the output waits
   logic rsp_valid_ff;
   logic adv;
   assign adv = !rsp_valid_ff || rsp_ready;

   // expand a cell into vertex requests
   logic                  vr_valid;
   usg_pkg::vert_req_type vr;

   usg_vertex_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .stack_index  (req_stack_index),
      .sector_index (req_sector_index),
      .sectors      (sectors),
      .stacks       (stacks),
      .adv          (adv),
      .vr_valid     (vr_valid),
      .vr           (vr)
   );

   // valid, corner and last travel beside the datapath
   usg_pkg::vert_tag_type tag_ff [TAG_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAG_LAT; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (adv) begin
         tag_ff[0] <= {vr_valid, vr.corner, vr.last};
         for (int k = 1; k < TAG_LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // phases: row * 2^PB / stacks (halved below), col * 2^PB / sectors
   logic [QB-1:0] quot_row, quot_col;

   usg_divider #(.QB(QB)) u_div_row (
      .clock (clock),
      .adv   (adv),
      .num   (vr.row),
      .den   (stacks),
      .quot  (quot_row)
   );

   usg_divider #(.QB(QB)) u_div_col (
      .clock (clock),
      .adv   (adv),
      .num   (vr.col),
      .den   (sectors),
      .quot  (quot_col)
   );

   logic [31:0]           phase_u_ff, phase_v_ff;
   logic [PHASE_BITS-1:0] su, sv;

   always_comb begin
      su = PHASE_BITS'(1 << (PHASE_BITS - 2)) - quot_row[QB-1:1];
      sv = quot_col[PHASE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phase_u_ff <= {su, {(32 - PHASE_BITS){1'b0}}};
         phase_v_ff <= {sv, {(32 - PHASE_BITS){1'b0}}};
      end
   end

   logic signed [TRIG_W-1:0] cos_u, sin_u, cos_v, sin_v;

   usg_cordic u_cordic_u (
      .clock (clock),
      .adv   (adv),
      .phase (phase_u_ff),
      .cos_q (cos_u),
      .sin_q (sin_u)
   );

   usg_cordic u_cordic_v (
      .clock (clock),
      .adv   (adv),
      .phase (phase_v_ff),
      .cos_q (cos_v),
      .sin_q (sin_v)
   );

   // first multiply: r * cos(u) for the ring radius, r * sin(u) for z
   logic signed [33:0]               xy_ff;
   logic signed [TRIG_W-1:0]         cv_ff, sv_ff;
   logic signed [usg_pkg::POS_W-1:0] pz1_ff, pz2_ff;
   logic signed [34:0]               prod_xy, prod_z, z_round;

   always_comb begin
      prod_xy = $signed({1'b0, radius_ff}) * cos_u;
      prod_z  = $signed({1'b0, radius_ff}) * sin_u;
      z_round = (prod_z + 35'sd32768) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xy_ff  <= prod_xy[33:0];
         pz1_ff <= usg_pkg::sat_pos(z_round[23:0]);
         cv_ff  <= cos_v;
         sv_ff  <= sin_v;
      end
   end

   // second multiply: ring radius split in two halves against cos(v) and sin(v)
   logic signed [17:0] xy_hi;
   logic signed [16:0] xy_lo;
   logic signed [35:0] pxh_ff, pyh_ff;
   logic signed [34:0] pxl_ff, pyl_ff;

   always_comb begin
      xy_hi = xy_ff[33:16];
      xy_lo = $signed({1'b0, xy_ff[15:0]});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxh_ff <= xy_hi * cv_ff;
         pxl_ff <= xy_lo * cv_ff;
         pyh_ff <= xy_hi * sv_ff;
         pyl_ff <= xy_lo * sv_ff;
         pz2_ff <= pz1_ff;
      end
   end

   // recombine, round half up and saturate into the output register
   logic signed [53:0] sum_x, sum_y;
   logic signed [usg_pkg::POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   usg_pkg::vert_tag_type out_tag_ff;

   always_comb begin
      sum_x = (54'(pxh_ff) <<< 16) + 54'(pxl_ff) + 54'sd2147483648;
      sum_y = (54'(pyh_ff) <<< 16) + 54'(pyl_ff) + 54'sd2147483648;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tag_ff[TAG_LAT-1].valid;
      end
      if (adv) begin
         pos_x_ff   <= usg_pkg::sat_pos(24'(signed'(sum_x[53:32])));
         pos_y_ff   <= usg_pkg::sat_pos(24'(signed'(sum_y[53:32])));
         pos_z_ff   <= pz2_ff;
         out_tag_ff <= tag_ff[TAG_LAT-1];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = pos_x_ff;
   assign rsp_pos_y        = pos_y_ff;
   assign rsp_pos_z        = pos_z_ff;
   assign rsp_corner       = out_tag_ff.corner;
   assign rsp_last_of_cell = out_tag_ff.last;

endmodule

>>> verif/uv_sphere_triangle_generator_test.sv
module uv_sphere_triangle_generator_test;

   localparam int  LATENCY_WAIT = 120;     // covers the pipeline, with margin
   localparam int  CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [usg_pkg::POS_W-1:0] x;
      logic signed [usg_pkg::POS_W-1:0] y;
      logic signed [usg_pkg::POS_W-1:0] z;
      usg_pkg::corner_type              corner;
      logic                             last;
   } vertex_type;

   typedef struct {
      logic [usg_pkg::IDX_W-1:0] stack;
      logic [usg_pkg::IDX_W-1:0] sector;
   } cell_type;

   // atan(2^-k) in fractions of a 32-bit turn
   localparam longint ATAN_TURN [usg_pkg::CORDIC_STEPS] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [usg_pkg::IDX_W-1:0] req_stack_index = '0;
   logic [usg_pkg::IDX_W-1:0] req_sector_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [usg_pkg::POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [1:0] rsp_corner;
   logic rsp_last_of_cell;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [usg_pkg::RAD_W-1:0] csr_write_data = '0;

   // configuration mirror
   int unsigned sector_count_q = 16;
   int unsigned stack_count_q  = 8;
   int unsigned radius_q       = 256;

   cell_type   pending_cells[$];
   vertex_type expected_vertices[$];
   int         error_count = 0;
   int         cycle_count = 0;
   bit         idling_on = 1'b1;

   uv_sphere_triangle_generator uut (.*);

   always #5 clock = ~clock;

   function automatic longint clamp_to(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // cos and sin of a 32-bit phase, Q16, clamped
   function automatic void cordic_q16(input logic [31:0] phase,
                                      output longint c, output longint s);
      longint x, y, z, nx;
      bit flip;
      x = 652032874;
      y = 0;
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (flip) phase = phase - 32'h8000_0000;
      z = longint'(signed'(phase));
      for (int k = 0; k < usg_pkg::CORDIC_STEPS; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            y  = y + (x >>> k);
            z  = z - ATAN_TURN[k];
         end else begin
            nx = x + (y >>> k);
            y  = y - (x >>> k);
            z  = z + ATAN_TURN[k];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp_to((x + 8192) >>> 14, 65536);
      s = clamp_to((y + 8192) >>> 14, 65536);
   endfunction

   function automatic vertex_type grid_vertex(input int unsigned a, input int unsigned b,
                                              input int unsigned sectors,
                                              input int unsigned stacks,
                                              input usg_pkg::corner_type corner,
                                              input logic last);
      logic [63:0] su, sv;
      longint cu, s_u, cv, s_v, r, xy;
      vertex_type v;
      su = 64'd16384 - ((64'(a) << 15) / stacks);
      sv = (64'(b) << 16) / sectors;
      cordic_q16({su[15:0], 16'h0}, cu, s_u);
      cordic_q16({sv[15:0], 16'h0}, cv, s_v);
      r  = longint'(radius_q);
      xy = r * cu;
      v.z = usg_pkg::POS_W'(clamp_to((r * s_u + 32768) >>> 16, 65535));
      v.x = usg_pkg::POS_W'(clamp_to((xy * cv + 64'sd2147483648) >>> 32, 65535));
      v.y = usg_pkg::POS_W'(clamp_to((xy * s_v + 64'sd2147483648) >>> 32, 65535));
      v.corner = corner;
      v.last = last;
      return v;
   endfunction

   // append one vertex to the expectation queue
   function automatic void expect_vertex(input vertex_type v);
      expected_vertices.insert(expected_vertices.size(), v);
   endfunction

   // queue the vertices one cell produces
   function automatic void predict_cell(input int unsigned i, input int unsigned j);
      int unsigned sectors, stacks;
      bit top, bottom;
      sectors = (sector_count_q > 256) ? 256 : sector_count_q;
      stacks  = (stack_count_q > 256) ? 256 : stack_count_q;
      if (sectors == 0 || stacks == 0 || i >= stacks || j >= sectors) return;
      top = (i == 0);
      bottom = (i == stacks - 1);
      if (!top) begin
         expect_vertex(grid_vertex(i, j, sectors, stacks, usg_pkg::CORNER_FIRST, 1'b0));
         expect_vertex(grid_vertex(i+1, j, sectors, stacks, usg_pkg::CORNER_SECOND, 1'b0));
         expect_vertex(grid_vertex(i, j+1, sectors, stacks, usg_pkg::CORNER_THIRD, bottom));
      end
      if (!bottom) begin
         expect_vertex(grid_vertex(i, j+1, sectors, stacks, usg_pkg::CORNER_FIRST, 1'b0));
         expect_vertex(grid_vertex(i+1, j, sectors, stacks, usg_pkg::CORNER_SECOND, 1'b0));
         expect_vertex(grid_vertex(i+1, j+1, sectors, stacks, usg_pkg::CORNER_THIRD, 1'b1));
      end
   endfunction

   // Driver: hold the payload while stalled, otherwise load the next cell or idle.
   always @(posedge clock) begin
      if (req_valid && req_ready) predict_cell(req_stack_index, req_sector_index);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         req_valid <= 1'b1;
      end else if (pending_cells.size() > 0 && !(idling_on && $urandom_range(99) < 26)) begin
         cell_type c;
         c = pending_cells.pop_front();
         req_valid <= 1'b1;
         req_stack_index <= c.stack;
         req_sector_index <= c.sector;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Monitor: random back-pressure, compare each transfer with the oldest expectation.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected vertex x=%0d y=%0d z=%0d corner=%0d last=%0b",
                        $time, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_corner,
                        rsp_last_of_cell);
               error_count++;
            end else begin
               vertex_type e;
               e = expected_vertices.pop_front();
               if (rsp_pos_x !== e.x || rsp_pos_y !== e.y || rsp_pos_z !== e.z ||
                   rsp_corner !== e.corner || rsp_last_of_cell !== e.last) begin
                  $display("%0t: mismatch expected x=%0d y=%0d z=%0d corner=%0d last=%0b",
                           $time, e.x, e.y, e.z, e.corner, e.last);
                  $display("%0t:          actual   x=%0d y=%0d z=%0d corner=%0d last=%0b",
                           $time, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_corner,
                           rsp_last_of_cell);
                  error_count++;
               end
            end
         end
         rsp_ready <= !(idling_on && $urandom_range(99) < 26);
      end
   end

   task automatic write_csr(input usg_pkg::csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= usg_pkg::RAD_W'(value);
      case (idx)
         usg_pkg::CSR_SECTOR_COUNT:  sector_count_q = value & 9'h1FF;
         usg_pkg::CSR_STACK_COUNT:   stack_count_q = value & 9'h1FF;
         usg_pkg::CSR_SPHERE_RADIUS: radius_q = value & 16'hFFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_cell(input int unsigned i, input int unsigned j);
      cell_type c;
      c.stack = usg_pkg::IDX_W'(i);
      c.sector = usg_pkg::IDX_W'(j);
      pending_cells.insert(pending_cells.size(), c);
   endtask

   // Wait until every cell is taken and every vertex is back, then let the pipeline drain.
   task automatic drain();
      while (pending_cells.size() > 0 || req_valid || expected_vertices.size() > 0)
         @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   // Mostly in-grid cells with random content, the rest anywhere in the index range.
   task automatic random_cells(input int n);
      int unsigned sectors, stacks;
      sectors = (sector_count_q > 256) ? 256 : sector_count_q;
      stacks  = (stack_count_q > 256) ? 256 : stack_count_q;
      repeat (n) begin
         if ($urandom_range(99) < 80 && sectors > 0 && stacks > 0)
            add_cell($urandom_range(stacks - 1), $urandom_range(sectors - 1));
         else
            add_cell($urandom_range(255), $urandom_range(255));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset grid: 16 sectors, 8 stacks, radius 256
      add_cell(0, 0);       // top stack: lower triangle only
      add_cell(7, 15);      // bottom stack and seam
      add_cell(1, 5);
      add_cell(3, 15);      // seam wraps to phase zero
      add_cell(8, 0);       // outside the grid
      add_cell(0, 16);      // outside the grid
      add_cell(255, 255);
      add_cell(4, 8);
      drain();

      // single stack: every cell is both top and bottom
      write_csr(usg_pkg::CSR_STACK_COUNT, 1);
      add_cell(0, 0);
      add_cell(0, 3);
      drain();

      // zero sectors: nothing is in the grid
      write_csr(usg_pkg::CSR_SECTOR_COUNT, 0);
      write_csr(usg_pkg::CSR_STACK_COUNT, 4);
      add_cell(0, 0);
      add_cell(2, 1);
      drain();

      // counts above the maximum saturate; zero radius
      write_csr(usg_pkg::CSR_SECTOR_COUNT, 511);
      write_csr(usg_pkg::CSR_STACK_COUNT, 300);
      write_csr(usg_pkg::CSR_SPHERE_RADIUS, 0);
      add_cell(255, 255);
      add_cell(0, 255);
      add_cell(128, 0);
      drain();

      // largest grid and radius, no idling on either side
      idling_on = 1'b0;
      write_csr(usg_pkg::CSR_SECTOR_COUNT, 256);
      write_csr(usg_pkg::CSR_STACK_COUNT, 256);
      write_csr(usg_pkg::CSR_SPHERE_RADIUS, 65535);
      add_cell(0, 0);
      add_cell(255, 255);
      add_cell(128, 64);
      random_cells(20);
      drain();
      idling_on = 1'b1;

      write_csr(usg_pkg::CSR_SECTOR_COUNT, 1);
      write_csr(usg_pkg::CSR_STACK_COUNT, 2);
      write_csr(usg_pkg::CSR_SPHERE_RADIUS, $urandom_range(65535));
      random_cells(12);
      drain();

      write_csr(usg_pkg::CSR_SECTOR_COUNT, 3);
      write_csr(usg_pkg::CSR_STACK_COUNT, 5);
      write_csr(usg_pkg::CSR_SPHERE_RADIUS, $urandom_range(65535));
      random_cells(20);
      drain();

      repeat (3) begin
         write_csr(usg_pkg::CSR_SECTOR_COUNT, $urandom_range(1, 40));
         write_csr(usg_pkg::CSR_STACK_COUNT, $urandom_range(1, 40));
         write_csr(usg_pkg::CSR_SPHERE_RADIUS, $urandom_range(65535));
         random_cells(16);
         drain();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
